/* rtl/string_literal_escape_decoder_core_defines.svh */
// Assertion macros used by the checker file of the escape decoder.
`ifndef STRING_LITERAL_ESCAPE_DECODER_CORE_DEFINES_SVH
`define STRING_LITERAL_ESCAPE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define SLED_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape decoder check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define SLED_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape decoder check failed");

`endif

/* rtl/sled_pkg.sv */
// Types, constants and helper functions of the string literal escape decoder.
`timescale 1ns / 1ps
package sled_pkg;

	localparam int HEX_ESCAPE_DIGITS   = 4;
	localparam int OCTAL_ESCAPE_DIGITS = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] ST_CHAR       = 3'd0;
	localparam logic [2:0] ST_END        = 3'd1;
	localparam logic [2:0] ST_EOF        = 3'd2;
	localparam logic [2:0] ST_BAD_U      = 3'd3;
	localparam logic [2:0] ST_BAD_DIGIT  = 3'd4;
	localparam logic [2:0] ST_SHORT_U    = 3'd5;
	localparam logic [2:0] ST_OCT_RANGE  = 3'd6;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

	localparam logic [15:0] CH_TAB       = 16'h0009;
	localparam logic [15:0] CH_CR        = 16'h000D;
	localparam logic [15:0] CH_LF        = 16'h000A;
	localparam logic [15:0] CH_BS        = 16'h0008;
	localparam logic [15:0] CH_FF        = 16'h000C;
	localparam logic [15:0] CH_SPACE     = 16'h0020;
	localparam logic [15:0] CH_COMMA     = 16'h002C;
	localparam logic [15:0] CH_QUOTE     = 16'h0022;
	localparam logic [15:0] CH_SEMI      = 16'h003B;
	localparam logic [15:0] CH_CARET     = 16'h005E;
	localparam logic [15:0] CH_LPAREN    = 16'h0028;
	localparam logic [15:0] CH_BACKSLASH = 16'h005C;
	localparam logic [15:0] CH_LOW_T     = 16'h0074;
	localparam logic [15:0] CH_LOW_R     = 16'h0072;
	localparam logic [15:0] CH_LOW_N     = 16'h006E;
	localparam logic [15:0] CH_LOW_B     = 16'h0062;
	localparam logic [15:0] CH_LOW_F     = 16'h0066;
	localparam logic [15:0] CH_LOW_U     = 16'h0075;
	localparam logic [15:0] CH_EIGHT     = 16'h0038;
	localparam logic [15:0] CH_NINE      = 16'h0039;
	localparam logic [15:0] OCTAL_MAX    = 16'h00FF;

	typedef struct packed {
		logic [15:0] ch;
		logic [2:0]  st;
	} res_t;

	// One queue entry holds every result caused by one input word.
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	function automatic logic is_blank(input logic [15:0] c);
		return c == CH_TAB || c == CH_SPACE || c == CH_COMMA || c == 16'h00A0 ||
			c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h202F || c == 16'h205F || c == 16'h3000;
	endfunction

	function automatic logic is_macro(input logic [15:0] c);
		return c == CH_QUOTE || c == CH_SEMI || c == CH_CARET || c == CH_LPAREN;
	endfunction

	// Returns {valid, value} for an ASCII hex digit.
	function automatic logic [4:0] hex_digit(input logic [15:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 16'h0030 && c <= 16'h0039)
			r = {1'b1, c[3:0]};
		else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	function automatic logic is_octal(input logic [15:0] c);
		return c[15:3] == 13'h0006;
	endfunction

endpackage

/* rtl/sled_front.sv */
// Front part: accepts code units, runs the escape state machine, packs results.
`timescale 1ns / 1ps
module sled_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_take,
	input  logic [15:0]       code_unit,
	input  logic              end_of_input,
	output logic              push,
	output sled_pkg::entry_t  push_entry
);
	import sled_pkg::*;

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_BACKSLASH,
		MODE_HEX,
		MODE_OCTAL
	} mode_t;

	typedef struct packed {
		logic emit;
		logic to_bs;
		res_t r;
	} plain_t;

	mode_t       mode_q, mode_d;
	logic [15:0] acc_q, acc_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        push_d;
	entry_t      ent;
	plain_t      pl;
	logic [4:0]  hx;
	logic [15:0] acc_hex, acc_oct;
	logic [2:0]  cnt_inc;

	function automatic plain_t plain_unit(input logic [15:0] c, input logic eof);
		plain_t p;
		p = '0;
		if (eof) begin
			p.emit = 1'b1;
			p.r = '{ch: 16'h0, st: ST_EOF};
		end else if (c == CH_QUOTE) begin
			p.emit = 1'b1;
			p.r = '{ch: 16'h0, st: ST_END};
		end else if (c == CH_BACKSLASH) begin
			p.to_bs = 1'b1;
		end else begin
			p.emit = 1'b1;
			p.r = '{ch: c, st: ST_CHAR};
		end
		return p;
	endfunction

	always_comb begin
		pl      = plain_unit(code_unit, end_of_input);
		hx      = hex_digit(code_unit);
		acc_hex = {acc_q[11:0], hx[3:0]};
		acc_oct = {acc_q[12:0], code_unit[2:0]};
		cnt_inc = cnt_q + 3'd1;
		mode_d  = mode_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		push_d  = 1'b0;
		ent     = '0;
		case (mode_q)
			MODE_PLAIN: begin
				push_d = pl.emit;
				ent.r0 = pl.r;
				mode_d = pl.to_bs ? MODE_BACKSLASH : MODE_PLAIN;
			end
			MODE_BACKSLASH: begin
				push_d = 1'b1;
				mode_d = MODE_PLAIN;
				acc_d  = 16'h0;
				cnt_d  = 3'd0;
				if (end_of_input) begin
					ent.r0 = '{ch: 16'h0, st: ST_EOF};
				end else if (code_unit == CH_LOW_T) begin
					ent.r0 = '{ch: CH_TAB, st: ST_CHAR};
				end else if (code_unit == CH_LOW_R) begin
					ent.r0 = '{ch: CH_CR, st: ST_CHAR};
				end else if (code_unit == CH_LOW_N) begin
					ent.r0 = '{ch: CH_LF, st: ST_CHAR};
				end else if (code_unit == CH_LOW_B) begin
					ent.r0 = '{ch: CH_BS, st: ST_CHAR};
				end else if (code_unit == CH_LOW_F) begin
					ent.r0 = '{ch: CH_FF, st: ST_CHAR};
				end else if (code_unit == CH_BACKSLASH || code_unit == CH_QUOTE) begin
					ent.r0 = '{ch: code_unit, st: ST_CHAR};
				end else if (code_unit == CH_LOW_U) begin
					push_d = 1'b0;
					mode_d = MODE_HEX;
				end else if (is_octal(code_unit)) begin
					// A one-digit octal limit finishes the escape at once.
					if (3'd1 >= 3'(OCTAL_ESCAPE_DIGITS)) begin
						ent.r0 = '{ch: {13'h0, code_unit[2:0]}, st: ST_CHAR};
					end else begin
						push_d = 1'b0;
						mode_d = MODE_OCTAL;
						acc_d  = {13'h0, code_unit[2:0]};
						cnt_d  = 3'd1;
					end
				end else if (code_unit == CH_EIGHT || code_unit == CH_NINE) begin
					ent.r0 = '{ch: 16'h0, st: ST_BAD_DIGIT};
				end else begin
					ent.r0 = '{ch: 16'h0, st: ST_UNSUPPORTED};
				end
			end
			MODE_HEX: begin
				if (end_of_input || !hx[4] || cnt_inc >= 3'(HEX_ESCAPE_DIGITS)) begin
					push_d = 1'b1;
					mode_d = MODE_PLAIN;
					acc_d  = 16'h0;
					cnt_d  = 3'd0;
					if (end_of_input)
						ent.r0 = '{ch: 16'h0, st: (cnt_q == 3'd0) ? ST_EOF : ST_SHORT_U};
					else if (!hx[4] && cnt_q == 3'd0)
						ent.r0 = '{ch: 16'h0, st: ST_BAD_U};
					else if (!hx[4] && (is_blank(code_unit) || is_macro(code_unit)))
						ent.r0 = '{ch: 16'h0, st: ST_SHORT_U};
					else if (!hx[4])
						ent.r0 = '{ch: 16'h0, st: ST_BAD_DIGIT};
					else
						ent.r0 = '{ch: acc_hex, st: ST_CHAR};
				end else begin
					acc_d = acc_hex;
					cnt_d = cnt_inc;
				end
			end
			MODE_OCTAL: begin
				if (end_of_input || is_blank(code_unit) || is_macro(code_unit)) begin
					// Emit the run's value, then treat the terminator as a body unit; an out-of-range run emits only its range error.
					push_d = 1'b1;
					mode_d = MODE_PLAIN;
					acc_d  = 16'h0;
					cnt_d  = 3'd0;
					if (acc_q > OCTAL_MAX) begin
						ent.r0 = '{ch: 16'h0, st: ST_OCT_RANGE};
					end else begin
						ent.r0  = '{ch: acc_q, st: ST_CHAR};
						ent.two = pl.emit;
						ent.r1  = pl.r;
						mode_d  = pl.to_bs ? MODE_BACKSLASH : MODE_PLAIN;
					end
				end else if (is_octal(code_unit)) begin
					if (cnt_inc >= 3'(OCTAL_ESCAPE_DIGITS)) begin
						push_d = 1'b1;
						mode_d = MODE_PLAIN;
						acc_d  = 16'h0;
						cnt_d  = 3'd0;
						if (acc_oct > OCTAL_MAX)
							ent.r0 = '{ch: 16'h0, st: ST_OCT_RANGE};
						else
							ent.r0 = '{ch: acc_oct, st: ST_CHAR};
					end else begin
						acc_d = acc_oct;
						cnt_d = cnt_inc;
					end
				end else begin
					push_d = 1'b1;
					mode_d = MODE_PLAIN;
					acc_d  = 16'h0;
					cnt_d  = 3'd0;
					ent.r0 = '{ch: 16'h0, st: ST_BAD_DIGIT};
				end
			end
			default: begin
				mode_d = MODE_PLAIN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			acc_q  <= 16'h0;
			cnt_q  <= 3'd0;
		end else if (in_take) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
		end
	end

	assign push       = in_take && push_d;
	assign push_entry = ent;

endmodule

/* rtl/sled_fifo.sv */
// Short queue of packed result entries between the front and back parts.
`timescale 1ns / 1ps
module sled_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  sled_pkg::entry_t  wdata,
	input  logic              rd,
	output sled_pkg::entry_t  rdata,
	output logic              full,
	output logic              nonempty
);
	import sled_pkg::*;

	entry_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wptr_q, rptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			if (wr && !rd)
				count_q <= count_q + 1'b1;
			else if (rd && !wr)
				count_q <= count_q - 1'b1;
		end
	end

	assign rdata    = slot_q[rptr_q];
	assign full     = count_q == QUEUE_CW'(QUEUE_DEPTH);
	assign nonempty = count_q != '0;

endmodule

/* rtl/sled_back.sv */
// Back part: unpacks queue entries into single results in an output register.
`timescale 1ns / 1ps
module sled_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  sled_pkg::entry_t  q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       char_value,
	output logic [2:0]        status,
	output logic              last_of_run
);
	import sled_pkg::*;

	logic        valid_q;
	logic        half_q;
	logic [15:0] char_q;
	logic [2:0]  status_q;
	logic        last_q;
	logic        load;
	logic        is_last;
	res_t        pick;

	assign load    = (!valid_q || out_ready) && q_nonempty;
	assign is_last = !q_head.two || half_q;
	assign pick    = half_q ? q_head.r1 : q_head.r0;
	assign q_pop   = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_nonempty;
			if (q_nonempty)
				half_q <= !is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q   <= pick.ch;
			status_q <= pick.st;
			last_q   <= is_last;
		end
	end

	assign out_valid   = valid_q;
	assign char_value  = char_q;
	assign status      = status_q;
	assign last_of_run = last_q;

endmodule

/* rtl/string_literal_escape_decoder_core.sv */
// String literal escape decoder: top level joining front, queue and back.
// Takes one code unit word per cycle while the four-entry result queue has room; a
// word's results are written into the queue at the edge that takes it and then pass
// through the output register. A word that gives two results (an octal run closed by a
// terminator) fills the output register twice, so the output side sets the sustained
// rate at one result per cycle while out_ready is high. Words that give no result (a
// backslash, the u of a unicode escape, inner digits) pass without touching the queue.
// Any nonzero status ends the string, and the next word starts a new string body.
`timescale 1ns / 1ps
module string_literal_escape_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] char_value,
	output logic [2:0]  status,
	output logic        last_of_run
);
	import sled_pkg::*;

	logic   q_full;
	logic   q_nonempty;
	logic   q_push;
	logic   q_pop;
	entry_t q_in;
	entry_t q_head;
	logic   in_take;

	assign in_ready = !q_full;
	assign in_take  = in_valid && in_ready;

	sled_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_take      (in_take),
		.code_unit    (code_unit),
		.end_of_input (end_of_input),
		.push         (q_push),
		.push_entry   (q_in)
	);

	sled_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wdata    (q_in),
		.rd       (q_pop),
		.rdata    (q_head),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	sled_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_value  (char_value),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

/* rtl/sled_checker.sv */
// Port-level checks of the escape decoder and their bind to the top level.
`timescale 1ns / 1ps
`include "string_literal_escape_decoder_core_defines.svh"
module sled_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] char_value,
	input logic [2:0]  status,
	input logic        last_of_run
);
	import sled_pkg::*;

	// A stalled word keeps its valid and its payload.
	`SLED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(char_value) && $stable(status) && $stable(last_of_run))

	// Every error or string end is the final result of its word.
	`SLED_ASSERT_NOW(a_status_last, out_valid && status != ST_CHAR, last_of_run)

	// Only a character carries a nonzero value.
	`SLED_ASSERT_NOW(a_status_zero_char, out_valid && status != ST_CHAR, char_value == 16'h0)

	// A first result that is not last is always a character from an octal run.
	`SLED_ASSERT_NOW(a_pair_first, out_valid && !last_of_run,
		status == ST_CHAR && char_value <= OCTAL_MAX)

endmodule

bind string_literal_escape_decoder_core sled_checker u_sled_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.char_value  (char_value),
	.status      (status),
	.last_of_run (last_of_run)
);

/* tb/string_literal_escape_decoder_core_tb.sv */
// Self-checking testbench for the string literal escape decoder core.
`timescale 1ns / 1ps
module string_literal_escape_decoder_core_tb;
	import sled_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 10;
	localparam int N_DIRECTED     = 30;
	localparam int RANDOM_UNITS   = 1650;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int REPORT_LIMIT   = 10;
	localparam int IDLE_PCT       = 16;
	localparam int PAUSE_AT       = 400;
	localparam int CALM_IN_FIRST  = 1100;
	localparam int CALM_IN_LAST   = 1400;
	localparam int HOLD_FIRST     = 700;
	localparam int HOLD_LAST      = 1000;
	localparam int CALM_OUT_FIRST = 1400;
	localparam int CALM_OUT_LAST  = 1800;

	typedef enum logic [1:0] {DEC_PLAIN, DEC_ESCAPE, DEC_HEX, DEC_OCTAL} dec_mode_t;

	typedef struct packed {
		logic [15:0] ch;
		logic [2:0]  st;
		logic        last;
	} decoded_t;

	// One input word; typed rows carry their single expected result.
	typedef struct packed {
		logic [15:0] cu;
		logic        eoi;
		logic        typed;
		logic [15:0] ch;
		logic [2:0]  st;
	} unit_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit = '0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] char_value;
	logic [2:0]  status;
	logic        last_of_run;

	dec_mode_t   mode;
	logic [15:0] acc;
	logic [2:0]  ndig;
	decoded_t    step_out [2];
	int          step_n;

	decoded_t    expected_chars [$];
	unit_row_t   unit_stream [$];
	unit_row_t   directed_rows [N_DIRECTED];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          out_cycle = 0;

	string_literal_escape_decoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_unit    (code_unit),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_value   (char_value),
		.status       (status),
		.last_of_run  (last_of_run)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Whitespace and macro characters both end an octal run early.
	function automatic bit is_run_stop(input logic [15:0] c);
		return c == CH_TAB || c == CH_SPACE || c == CH_COMMA || c == 16'h00A0 ||
			c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) || c == 16'h202F ||
			c == 16'h205F || c == 16'h3000 || c == CH_QUOTE || c == CH_SEMI ||
			c == CH_CARET || c == CH_LPAREN;
	endfunction

	function automatic int hex_nibble(input logic [15:0] c);
		if (c >= 16'h0030 && c <= 16'h0039)
			return int'(c - 16'h0030);
		if (c >= 16'h0061 && c <= 16'h0066)
			return int'(c - 16'h0061) + 10;
		if (c >= 16'h0041 && c <= 16'h0046)
			return int'(c - 16'h0041) + 10;
		return -1;
	endfunction

	function automatic void reset_decoder();
		mode = DEC_PLAIN;
		acc  = '0;
		ndig = '0;
	endfunction

	// Any nonzero status ends the string and drops the decoder back to its start.
	function automatic void emit(input logic [15:0] ch, input logic [2:0] st);
		step_out[step_n] = '{ch: ch, st: st, last: 1'b0};
		step_n++;
		if (st != ST_CHAR)
			reset_decoder();
	endfunction

	function automatic void body_unit(input logic [15:0] c, input logic eoi);
		if (eoi)
			emit('0, ST_EOF);
		else if (c == CH_QUOTE)
			emit('0, ST_END);
		else if (c == CH_BACKSLASH)
			mode = DEC_ESCAPE;
		else
			emit(c, ST_CHAR);
	endfunction

	function automatic void close_octal();
		if (acc > OCTAL_MAX) begin
			emit('0, ST_OCT_RANGE);
		end else begin
			emit(acc, ST_CHAR);
			reset_decoder();
		end
	endfunction

	function automatic void decode_unit(input logic [15:0] c, input logic eoi);
		int d;
		step_n = 0;
		d = hex_nibble(c);
		case (mode)
		DEC_PLAIN: begin
			body_unit(c, eoi);
		end
		DEC_ESCAPE: begin
			if (eoi) begin
				emit('0, ST_EOF);
			end else begin
				mode = DEC_PLAIN;
				if (c == CH_LOW_T)
					emit(CH_TAB, ST_CHAR);
				else if (c == CH_LOW_R)
					emit(CH_CR, ST_CHAR);
				else if (c == CH_LOW_N)
					emit(CH_LF, ST_CHAR);
				else if (c == CH_LOW_B)
					emit(CH_BS, ST_CHAR);
				else if (c == CH_LOW_F)
					emit(CH_FF, ST_CHAR);
				else if (c == CH_BACKSLASH || c == CH_QUOTE)
					emit(c, ST_CHAR);
				else if (c == CH_LOW_U) begin
					mode = DEC_HEX;
					acc  = '0;
					ndig = '0;
				end else if (c >= 16'h0030 && c <= 16'h0037) begin
					mode = DEC_OCTAL;
					acc  = c - 16'h0030;
					ndig = 3'd1;
					if (ndig >= OCTAL_ESCAPE_DIGITS)
						close_octal();
				end else if (c == CH_EIGHT || c == CH_NINE)
					emit('0, ST_BAD_DIGIT);
				else
					emit('0, ST_UNSUPPORTED);
			end
		end
		DEC_HEX: begin
			if (eoi) begin
				emit('0, ndig == 0 ? ST_EOF : ST_SHORT_U);
			end else if (d < 0) begin
				if (ndig == 0)
					emit('0, ST_BAD_U);
				else if (is_run_stop(c))
					emit('0, ST_SHORT_U);
				else
					emit('0, ST_BAD_DIGIT);
			end else begin
				acc = {acc[11:0], 4'(d)};
				ndig++;
				if (ndig >= HEX_ESCAPE_DIGITS) begin
					emit(acc, ST_CHAR);
					reset_decoder();
				end
			end
		end
		default: begin
			// A terminator closes the run and, if the run is in range, is then decoded as a body word.
			if (eoi || is_run_stop(c)) begin
				close_octal();
				if (step_out[0].st == ST_CHAR)
					body_unit(c, eoi);
			end else if (c >= 16'h0030 && c <= 16'h0037) begin
				acc = acc * 16'd8 + (c - 16'h0030);
				ndig++;
				if (ndig >= OCTAL_ESCAPE_DIGITS)
					close_octal();
			end else begin
				emit('0, ST_BAD_DIGIT);
			end
		end
		endcase
	endfunction

	function automatic void push_unit(input logic [15:0] c, input logic eoi);
		unit_stream.push_back('{cu: c, eoi: eoi, typed: 1'b0, ch: '0, st: ST_CHAR});
	endfunction

	function automatic logic [15:0] any_terminator();
		case ($urandom_range(0, 12))
		0: return CH_TAB;
		1: return CH_SPACE;
		2: return CH_COMMA;
		3: return 16'h00A0;
		4: return 16'h1680;
		5: return 16'h2000 + 16'($urandom_range(0, 10));
		6: return 16'h202F;
		7: return 16'h205F;
		8: return 16'h3000;
		9: return CH_QUOTE;
		10: return CH_SEMI;
		11: return CH_CARET;
		default: return CH_LPAREN;
		endcase
	endfunction

	function automatic logic [15:0] any_hex_digit();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10)
			return 16'h0030 + 16'(v);
		if (v < 16)
			return 16'h0061 + 16'(v - 10);
		return 16'h0041 + 16'(v - 16);
	endfunction

	// Random noise, well-formed escapes with random content, quotes, end markers and broken escapes.
	function automatic void add_random_fragment();
		int pick;
		int n;
		int k;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			case ($urandom_range(0, 2))
			0: push_unit(16'h0020 + 16'($urandom_range(0, 94)), 1'b0);
			1: push_unit(16'($urandom), 1'b0);
			default: push_unit(any_terminator(), 1'b0);
			endcase
		end else if (pick < 45) begin
			push_unit(CH_BACKSLASH, 1'b0);
			case ($urandom_range(0, 6))
			0: push_unit(CH_LOW_T, 1'b0);
			1: push_unit(CH_LOW_R, 1'b0);
			2: push_unit(CH_LOW_N, 1'b0);
			3: push_unit(CH_LOW_B, 1'b0);
			4: push_unit(CH_LOW_F, 1'b0);
			5: push_unit(CH_BACKSLASH, 1'b0);
			default: push_unit(CH_QUOTE, 1'b0);
			endcase
		end else if (pick < 60) begin
			push_unit(CH_BACKSLASH, 1'b0);
			push_unit(CH_LOW_U, 1'b0);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, HEX_ESCAPE_DIGITS - 1)
				: HEX_ESCAPE_DIGITS;
			for (k = 0; k < n; k++)
				push_unit(any_hex_digit(), 1'b0);
			if (n < HEX_ESCAPE_DIGITS) begin
				case ($urandom_range(0, 2))
				0: push_unit(any_terminator(), 1'b0);
				1: push_unit(16'($urandom), 1'b0);
				default: push_unit(16'($urandom), 1'b1);
				endcase
			end
		end else if (pick < 75) begin
			push_unit(CH_BACKSLASH, 1'b0);
			n = $urandom_range(1, OCTAL_ESCAPE_DIGITS);
			for (k = 0; k < n; k++)
				push_unit(16'h0030 + 16'($urandom_range(0, 7)), 1'b0);
			if (n < OCTAL_ESCAPE_DIGITS) begin
				case ($urandom_range(0, 5))
				0: push_unit(16'($urandom), 1'b1);
				1: push_unit(16'($urandom), 1'b0);
				default: push_unit(any_terminator(), 1'b0);
				endcase
			end
		end else if (pick < 82) begin
			push_unit(CH_QUOTE, 1'b0);
		end else if (pick < 86) begin
			push_unit(16'($urandom), 1'b1);
		end else if (pick < 93) begin
			push_unit(CH_BACKSLASH, 1'b0);
			if ($urandom_range(0, 3) == 0)
				push_unit(CH_EIGHT + 16'($urandom_range(0, 1)), 1'b0);
			else
				push_unit(16'($urandom), 1'($urandom_range(0, 9) == 0));
		end else begin
			push_unit(16'($urandom), 1'($urandom_range(0, 1)));
		end
	endfunction

	task automatic send_units();
		int       k;
		int       j;
		bit       calm;
		decoded_t r;
		for (k = 0; k < unit_stream.size(); k++) begin
			if (k == PAUSE_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_chars.size() != 0)
					@(posedge clk);
			end
			calm = k >= CALM_IN_FIRST && k < CALM_IN_LAST;
			while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid     <= 1'b1;
			code_unit    <= unit_stream[k].cu;
			end_of_input <= unit_stream[k].eoi;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			decode_unit(unit_stream[k].cu, unit_stream[k].eoi);
			if (unit_stream[k].typed) begin
				expected_chars.push_back('{ch: unit_stream[k].ch, st: unit_stream[k].st,
					last: 1'b1});
			end else begin
				for (j = 0; j < step_n; j++) begin
					r = step_out[j];
					r.last = (j == step_n - 1);
					expected_chars.push_back(r);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		decoded_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected word ch=%h st=%0d last=%0b", $time,
						char_value, status, last_of_run);
			end else begin
				want = expected_chars.pop_front();
				if (char_value !== want.ch || status !== want.st || last_of_run !== want.last)
				begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: expected ch=%h st=%0d last=%0b, got ch=%h st=%0d last=%0b",
							$time, want.ch, want.st, want.last, char_value, status, last_of_run);
				end
			end
		end
	end

	// The long hold-off lets the result queue fill so the input side stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			out_cycle++;
			if (out_cycle >= HOLD_FIRST && out_cycle < HOLD_LAST)
				out_ready <= 1'b0;
			else if (out_cycle >= CALM_OUT_FIRST && out_cycle < CALM_OUT_LAST)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		directed_rows = '{
			'{16'h0000, 1'b0, 1'b1, 16'h0000, ST_CHAR},
			'{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, ST_CHAR},
			'{16'hFFFF, 1'b1, 1'b1, 16'h0000, ST_EOF},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_LOW_U, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0046, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0066, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0030, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0039, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0034, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0030, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0030, 1'b0, 1'b1, 16'h0000, ST_OCT_RANGE},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0037, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_SPACE, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_NINE, 1'b0, 1'b1, 16'h0000, ST_BAD_DIGIT},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0071, 1'b0, 1'b1, 16'h0000, ST_UNSUPPORTED},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_LOW_U, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0067, 1'b0, 1'b1, 16'h0000, ST_BAD_U},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_LOW_U, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0061, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{CH_SEMI, 1'b0, 1'b1, 16'h0000, ST_SHORT_U},
			'{CH_BACKSLASH, 1'b0, 1'b0, 16'h0000, ST_CHAR},
			'{16'h0000, 1'b1, 1'b1, 16'h0000, ST_EOF},
			'{CH_QUOTE, 1'b0, 1'b1, 16'h0000, ST_END}
		};
		reset_decoder();
		foreach (directed_rows[i])
			unit_stream.push_back(directed_rows[i]);
		while (unit_stream.size() < N_DIRECTED + RANDOM_UNITS)
			add_random_fragment();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_units();

		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sled_pkg.sv
rtl/sled_front.sv
rtl/sled_fifo.sv
rtl/sled_back.sv
rtl/string_literal_escape_decoder_core.sv
rtl/sled_checker.sv
tb/string_literal_escape_decoder_core_tb.sv
